// ===== rtl/pip_pkg.sv =====
`timescale 1ns / 1ps

package pip_pkg;

	localparam int MAX_VERTICES_DEF = 256;
	localparam int COORD_BITS_DEF   = 20;

	localparam int VCNT_W   = 9;
	localparam int VIDX_W   = 8;
	localparam int USER_W   = 1;
	localparam int M_DATA_W = 8;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

endpackage

// ===== rtl/pip_vstore.sv =====
`timescale 1ns / 1ps

module pip_vstore #(
	parameter int DEPTH  = 256,
	parameter int ADDR_W = 8,
	parameter int WIDTH  = 40
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/pip_mul.sv =====
`timescale 1ns / 1ps

module pip_mul #(
	parameter int OP_W = 21
) (
	input  logic                   clk,
	input  logic signed [OP_W-1:0]   a,
	input  logic signed [OP_W-1:0]   b,
	output logic signed [2*OP_W-1:0] p
);

	logic signed [2*OP_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

// ===== rtl/pip_seq.sv =====
`timescale 1ns / 1ps

module pip_seq
	import pip_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int ADDR_W     = 8,
	localparam int DW        = COORD_BITS + 1,
	localparam int PW        = 2 * DW
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        empty,
	input  logic [ADDR_W-1:0]           last_idx,
	input  logic signed [COORD_BITS-1:0] qx,
	input  logic signed [COORD_BITS-1:0] qy,
	output logic                        idle,
	output logic [ADDR_W-1:0]           raddr,
	input  logic signed [COORD_BITS-1:0] rd_x,
	input  logic signed [COORD_BITS-1:0] rd_y,
	output logic signed [DW-1:0]        mul_a,
	output logic signed [DW-1:0]        mul_b,
	input  logic signed [PW-1:0]        mul_p,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic                        res_inside
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PRIME,
		S_PREV,
		S_EDGE,
		S_MUL1,
		S_MUL2,
		S_CMP,
		S_DONE
	} state_t;

	state_t state_q;

	logic [ADDR_W-1:0]           raddr_q;
	logic [ADDR_W-1:0]           idx_q;
	logic [ADDR_W-1:0]           last_q;
	logic signed [COORD_BITS-1:0] px_q;
	logic signed [COORD_BITS-1:0] py_q;
	logic signed [COORD_BITS-1:0] prev_x_q;
	logic signed [COORD_BITS-1:0] prev_y_q;
	logic signed [COORD_BITS-1:0] cur_x_q;
	logic signed [COORD_BITS-1:0] cur_y_q;
	logic signed [DW-1:0]        a_q;
	logic signed [DW-1:0]        b_q;
	logic signed [DW-1:0]        c_q;
	logic signed [DW-1:0]        d_q;
	logic                        cross_q;
	logic                        dy_neg_q;
	logic signed [PW-1:0]        p_q;
	logic                        parity_q;
	logic                        res_valid_q;
	logic                        res_inside_q;

	logic signed [DW-1:0]  px_e, py_e, xi_e, yi_e, xj_e, yj_e;
	logic signed [DW-1:0]  dy_c;
	logic signed [PW:0]    diff;
	logic                  flip;

	assign px_e = {px_q[COORD_BITS-1], px_q};
	assign py_e = {py_q[COORD_BITS-1], py_q};
	assign xi_e = {rd_x[COORD_BITS-1], rd_x};
	assign yi_e = {rd_y[COORD_BITS-1], rd_y};
	assign xj_e = {prev_x_q[COORD_BITS-1], prev_x_q};
	assign yj_e = {prev_y_q[COORD_BITS-1], prev_y_q};
	assign dy_c = yj_e - yi_e;

	assign diff = {p_q[PW-1], p_q} - {mul_p[PW-1], mul_p};
	assign flip = cross_q && (diff != '0) && (diff[PW] != dy_neg_q);

	always_comb begin
		if (state_q == S_MUL1) begin
			mul_a = a_q;
			mul_b = b_q;
		end else begin
			mul_a = c_q;
			mul_b = d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
			parity_q    <= 1'b0;
		end else begin
			if (res_valid_q && res_ready && (state_q != S_DONE)) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						px_q     <= qx;
						py_q     <= qy;
						last_q   <= last_idx;
						raddr_q  <= last_idx;
						idx_q    <= '0;
						parity_q <= 1'b0;
						state_q  <= empty ? S_DONE : S_PRIME;
					end
				end
				S_PRIME: begin
					raddr_q <= '0;
					state_q <= S_PREV;
				end
				S_PREV: begin
					prev_x_q <= rd_x;
					prev_y_q <= rd_y;
					state_q  <= S_EDGE;
				end
				S_EDGE: begin
					cur_x_q  <= rd_x;
					cur_y_q  <= rd_y;
					a_q      <= px_e - xi_e;
					b_q      <= dy_c;
					c_q      <= xj_e - xi_e;
					d_q      <= py_e - yi_e;
					cross_q  <= (rd_y > py_q) != (prev_y_q > py_q);
					dy_neg_q <= dy_c[DW-1];
					raddr_q  <= idx_q + 1'b1;
					state_q  <= S_MUL1;
				end
				S_MUL1: begin
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					p_q     <= mul_p;
					state_q <= S_CMP;
				end
				S_CMP: begin
					parity_q <= parity_q ^ flip;
					prev_x_q <= cur_x_q;
					prev_y_q <= cur_y_q;
					idx_q    <= idx_q + 1'b1;
					state_q  <= (idx_q == last_q) ? S_DONE : S_EDGE;
				end
				S_DONE: begin
					if (!res_valid_q || res_ready) begin
						res_valid_q  <= 1'b1;
						res_inside_q <= parity_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign idle       = (state_q == S_IDLE);
	assign raddr      = raddr_q;
	assign res_valid  = res_valid_q;
	assign res_inside = res_inside_q;

endmodule

// ===== rtl/point_in_polygon_test.sv =====
`timescale 1ns / 1ps
// Channel       Direction  Fields (lowest bit up)
// s_t*          in         tuser: operation; tdata: vertex_index, coord_x, coord_y, zero fill
// m_t*          out        tdata: inside_res, zero fill
// vertex_count  in         write enable and 9-bit write data, no read-back
//
// A load writes one vertex into the store unless its vertex_index is MAX_VERTICES or more.
// A query walks one edge per vertex, the vertex count saturated at MAX_VERTICES:
// each edge costs one store read plus two passes through the shared multiplier
// and one compare. An empty polygon skips the walk and answers outside.
// Reset clears the sequencer, output valid and vertex_count; the store is not cleared.
// A result held by m_tready stalls the next query at its final step.

module point_in_polygon_test
	import pip_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int COORD_BITS   = COORD_BITS_DEF,
	localparam int ADDR_W      = $clog2(MAX_VERTICES),
	localparam int S_DATA_W    = ((VIDX_W + 2 * COORD_BITS + 7) / 8) * 8,
	localparam int DW          = COORD_BITS + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_DATA_W-1:0]  s_tdata,  // vertex_index, coord_x, coord_y
	input  logic [USER_W-1:0]    s_tuser,  // operation
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_DATA_W-1:0]  m_tdata,  // inside_res
	input  logic                 vertex_count_we,
	input  logic [VCNT_W-1:0]    vertex_count_wdata
);

	logic [VCNT_W-1:0] vertex_count_q;

	logic                         accept;
	logic                         idle;
	logic [VIDX_W-1:0]            in_idx;
	logic signed [COORD_BITS-1:0] in_x;
	logic signed [COORD_BITS-1:0] in_y;
	logic [31:0]                  idx32;
	logic [31:0]                  cnt32;
	logic [31:0]                  last32;
	logic                         we;
	logic [ADDR_W-1:0]            raddr;
	logic [2*COORD_BITS-1:0]      rdata;
	logic signed [DW-1:0]         mul_a;
	logic signed [DW-1:0]         mul_b;
	logic signed [2*DW-1:0]       mul_p;
	logic                         in_poly;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= '0;
		end else if (vertex_count_we) begin
			vertex_count_q <= vertex_count_wdata;
		end
	end

	assign in_idx = s_tdata[VIDX_W-1:0];
	assign in_x   = s_tdata[VIDX_W +: COORD_BITS];
	assign in_y   = s_tdata[VIDX_W + COORD_BITS +: COORD_BITS];

	assign s_tready = idle;
	assign accept   = s_tvalid && s_tready;

	assign idx32  = 32'(in_idx);
	assign cnt32  = 32'(vertex_count_q);
	assign last32 = (cnt32 > 32'(MAX_VERTICES)) ? 32'(MAX_VERTICES - 1) : cnt32 - 32'd1;
	assign we     = accept && (s_tuser[0] == OP_LOAD) && (idx32 < 32'(MAX_VERTICES));

	pip_vstore #(
		.DEPTH  (MAX_VERTICES),
		.ADDR_W (ADDR_W),
		.WIDTH  (2 * COORD_BITS)
	) u_vstore (
		.clk   (clk),
		.we    (we),
		.waddr (idx32[ADDR_W-1:0]),
		.wdata ({in_y, in_x}),
		.raddr (raddr),
		.rdata (rdata)
	);

	pip_mul #(
		.OP_W (DW)
	) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	pip_seq #(
		.COORD_BITS (COORD_BITS),
		.ADDR_W     (ADDR_W)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (accept && (s_tuser[0] == OP_QUERY)),
		.empty      (vertex_count_q == '0),
		.last_idx   (last32[ADDR_W-1:0]),
		.qx         (in_x),
		.qy         (in_y),
		.idle       (idle),
		.raddr      (raddr),
		.rd_x       (rdata[COORD_BITS-1:0]),
		.rd_y       (rdata[2*COORD_BITS-1:COORD_BITS]),
		.mul_a      (mul_a),
		.mul_b      (mul_b),
		.mul_p      (mul_p),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res_inside (in_poly)
	);

	assign m_tdata = {{(M_DATA_W - 1){1'b0}}, in_poly};

endmodule
